[src/md5_pkg.sv]
// Package: MD5 core item types and round constants.
`timescale 1ns / 1ps
package md5_pkg;

  typedef struct packed {
    logic [7:0] data_byte;
    logic       last_byte;
    logic       no_data;
  } in_item_t;

  typedef struct packed {
    logic [63:0] digest_half;
    logic        half_index;
    logic        digest_last;
  } out_item_t;

  localparam logic [31:0] IV_A = 32'h67452301;
  localparam logic [31:0] IV_B = 32'hefcdab89;
  localparam logic [31:0] IV_C = 32'h98badcfe;
  localparam logic [31:0] IV_D = 32'h10325476;
  localparam logic [7:0]  PAD_BYTE = 8'h80;
  localparam logic [5:0]  LEN_POS = 6'd56;

  // Additive constant for step s
  function automatic logic [31:0] sine_k(input logic [5:0] s);
    logic [31:0] k;
    unique case (s)
      6'd0: k = 32'hd76aa478;  6'd1: k = 32'he8c7b756;  6'd2: k = 32'h242070db;
      6'd3: k = 32'hc1bdceee;  6'd4: k = 32'hf57c0faf;  6'd5: k = 32'h4787c62a;
      6'd6: k = 32'ha8304613;  6'd7: k = 32'hfd469501;  6'd8: k = 32'h698098d8;
      6'd9: k = 32'h8b44f7af;  6'd10: k = 32'hffff5bb1; 6'd11: k = 32'h895cd7be;
      6'd12: k = 32'h6b901122; 6'd13: k = 32'hfd987193; 6'd14: k = 32'ha679438e;
      6'd15: k = 32'h49b40821; 6'd16: k = 32'hf61e2562; 6'd17: k = 32'hc040b340;
      6'd18: k = 32'h265e5a51; 6'd19: k = 32'he9b6c7aa; 6'd20: k = 32'hd62f105d;
      6'd21: k = 32'h02441453; 6'd22: k = 32'hd8a1e681; 6'd23: k = 32'he7d3fbc8;
      6'd24: k = 32'h21e1cde6; 6'd25: k = 32'hc33707d6; 6'd26: k = 32'hf4d50d87;
      6'd27: k = 32'h455a14ed; 6'd28: k = 32'ha9e3e905; 6'd29: k = 32'hfcefa3f8;
      6'd30: k = 32'h676f02d9; 6'd31: k = 32'h8d2a4c8a; 6'd32: k = 32'hfffa3942;
      6'd33: k = 32'h8771f681; 6'd34: k = 32'h6d9d6122; 6'd35: k = 32'hfde5380c;
      6'd36: k = 32'ha4beea44; 6'd37: k = 32'h4bdecfa9; 6'd38: k = 32'hf6bb4b60;
      6'd39: k = 32'hbebfbc70; 6'd40: k = 32'h289b7ec6; 6'd41: k = 32'heaa127fa;
      6'd42: k = 32'hd4ef3085; 6'd43: k = 32'h04881d05; 6'd44: k = 32'hd9d4d039;
      6'd45: k = 32'he6db99e5; 6'd46: k = 32'h1fa27cf8; 6'd47: k = 32'hc4ac5665;
      6'd48: k = 32'hf4292244; 6'd49: k = 32'h432aff97; 6'd50: k = 32'hab9423a7;
      6'd51: k = 32'hfc93a039; 6'd52: k = 32'h655b59c3; 6'd53: k = 32'h8f0ccc92;
      6'd54: k = 32'hffeff47d; 6'd55: k = 32'h85845dd1; 6'd56: k = 32'h6fa87e4f;
      6'd57: k = 32'hfe2ce6e0; 6'd58: k = 32'ha3014314; 6'd59: k = 32'h4e0811a1;
      6'd60: k = 32'hf7537e82; 6'd61: k = 32'hbd3af235; 6'd62: k = 32'h2ad7d2bb;
      default: k = 32'heb86d391;
    endcase
    return k;
  endfunction

  // Rotate amount for step s
  function automatic logic [4:0] rot_amt(input logic [5:0] s);
    logic [4:0] r;
    unique case ({s[5:4], s[1:0]})
      4'd0: r = 5'd7;   4'd1: r = 5'd12;  4'd2: r = 5'd17;  4'd3: r = 5'd22;
      4'd4: r = 5'd5;   4'd5: r = 5'd9;   4'd6: r = 5'd14;  4'd7: r = 5'd20;
      4'd8: r = 5'd4;   4'd9: r = 5'd11;  4'd10: r = 5'd16; 4'd11: r = 5'd23;
      4'd12: r = 5'd6;  4'd13: r = 5'd10; 4'd14: r = 5'd15; default: r = 5'd21;
    endcase
    return r;
  endfunction

endpackage

[src/md5_fifo.sv]
// Short queue of input items between the front and the compression engine.
`timescale 1ns / 1ps
module md5_fifo #(
  parameter int Depth = 4
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             push,
  input  md5_pkg::in_item_t push_item,
  output logic             full,
  input  logic             pop,
  output logic             empty,
  output md5_pkg::in_item_t pop_item
);
  localparam int AW = (Depth > 1) ? $clog2(Depth) : 1;

  md5_pkg::in_item_t mem_r [Depth];
  logic [AW-1:0] wp_r, rp_r;
  logic [AW:0]   cnt_r;

  assign full     = (cnt_r == (AW+1)'(Depth));
  assign empty    = (cnt_r == '0);
  assign pop_item = mem_r[rp_r];

  // Storage
  always_ff @(posedge clk) begin
    if (push && !full) mem_r[wp_r] <= push_item;
  end

  // Pointers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r <= '0; rp_r <= '0; cnt_r <= '0;
    end else begin
      if (push && !full) wp_r <= (wp_r == AW'(Depth-1)) ? '0 : wp_r + 1'b1;
      if (pop && !empty) rp_r <= (rp_r == AW'(Depth-1)) ? '0 : rp_r + 1'b1;
      cnt_r <= cnt_r + (AW+1)'(push && !full) - (AW+1)'(pop && !empty);
    end
  end
endmodule

[src/md5_engine.sv]
// Back end: block assembly, padding, 64-step compression and digest output.
`timescale 1ns / 1ps
module md5_engine (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              q_empty,
  input  md5_pkg::in_item_t q_item,
  output logic              q_pop,
  output logic              out_valid,
  input  logic              out_stall,
  output md5_pkg::out_item_t out_item
);
  typedef enum logic [2:0] {
    ST_TAKE, ST_COMP, ST_PAD, ST_OUT0, ST_OUT1
  } state_t;

  state_t       state_r;
  logic [31:0]  chain_r [4];
  logic [31:0]  blk_r [16];
  logic [60:0]  cnt_r;
  logic [31:0]  a_r, b_r, c_r, d_r;
  logic [5:0]   step_r;
  logic         fin_r;    // message end pending
  logic         two_r;    // padding needs a second block
  logic         lenb_r;   // block being compressed is the length block
  logic         ov_r;
  logic         hi_r;

  // Step datapath
  logic [31:0] f, t, rot, mw;
  logic [3:0]  g;
  logic [4:0]  sh;
  always_comb begin
    unique case (step_r[5:4])
      2'd0: begin f = (b_r & c_r) | (~b_r & d_r); g = step_r[3:0]; end
      2'd1: begin f = (b_r & d_r) | (c_r & ~d_r); g = 4'(5*step_r[3:0] + 1); end
      2'd2: begin f = b_r ^ c_r ^ d_r;            g = 4'(3*step_r[3:0] + 5); end
      default: begin f = c_r ^ (b_r | ~d_r);     g = 4'(7*step_r[3:0]); end
    endcase
    mw  = blk_r[g];
    t   = a_r + f + mw + md5_pkg::sine_k(step_r);
    sh  = md5_pkg::rot_amt(step_r);
    rot = (t << sh) | (t >> (6'd32 - {1'b0, sh}));
  end

  // Digest halves, earliest byte in the top lane
  function automatic logic [63:0] half(input logic [31:0] w0, input logic [31:0] w1);
    return {w0[7:0], w0[15:8], w0[23:16], w0[31:24],
            w1[7:0], w1[15:8], w1[23:16], w1[31:24]};
  endfunction

  logic [5:0] pos;
  logic [3:0] pw;
  logic [1:0] pl;
  logic [63:0] bits;
  assign pos  = cnt_r[5:0];
  assign pw   = pos[5:2];
  assign pl   = pos[1:0];
  assign bits = {cnt_r, 3'b000};

  assign q_pop     = (state_r == ST_TAKE) && !q_empty;
  assign out_valid = ov_r;
  assign out_item.digest_half = hi_r ? half(chain_r[2], chain_r[3])
                                     : half(chain_r[0], chain_r[1]);
  assign out_item.half_index  = hi_r;
  assign out_item.digest_last = hi_r;

  // Block buffer (no reset)
  always_ff @(posedge clk) begin
    if (state_r == ST_TAKE && !q_empty && !q_item.no_data) begin
      unique case (pl)
        2'd0: blk_r[pw] <= {24'd0, q_item.data_byte};
        2'd1: blk_r[pw][15:8] <= q_item.data_byte;
        2'd2: blk_r[pw][23:16] <= q_item.data_byte;
        default: blk_r[pw][31:24] <= q_item.data_byte;
      endcase
    end else if (state_r == ST_PAD) begin
      // first pass: pad byte, clear following words, place the length if it fits; second pass: zeros and the length
      for (int w = 0; w < 16; w++) begin
        if (two_r) begin
          if (w == 14) blk_r[w] <= bits[31:0];
          else if (w == 15) blk_r[w] <= bits[63:32];
          else blk_r[w] <= '0;
        end else if (4'(w) == pw) begin
          unique case (pl)
            2'd0: blk_r[w] <= {24'd0, md5_pkg::PAD_BYTE};
            2'd1: blk_r[w] <= {16'd0, md5_pkg::PAD_BYTE, blk_r[w][7:0]};
            2'd2: blk_r[w] <= {8'd0, md5_pkg::PAD_BYTE, blk_r[w][15:0]};
            default: blk_r[w] <= {md5_pkg::PAD_BYTE, blk_r[w][23:0]};
          endcase
        end else if (4'(w) > pw) begin
          if (pos < md5_pkg::LEN_POS && w == 14) blk_r[w] <= bits[31:0];
          else if (pos < md5_pkg::LEN_POS && w == 15) blk_r[w] <= bits[63:32];
          else blk_r[w] <= '0;
        end
      end
    end
  end

  // Control and chaining state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_TAKE;
      chain_r[0] <= md5_pkg::IV_A; chain_r[1] <= md5_pkg::IV_B;
      chain_r[2] <= md5_pkg::IV_C; chain_r[3] <= md5_pkg::IV_D;
      cnt_r <= '0; step_r <= '0;
      a_r <= '0; b_r <= '0; c_r <= '0; d_r <= '0;
      fin_r <= 1'b0; two_r <= 1'b0; lenb_r <= 1'b0;
      ov_r <= 1'b0; hi_r <= 1'b0;
    end else begin
      unique case (state_r)
        ST_TAKE: if (!q_empty) begin
          fin_r <= q_item.last_byte;
          two_r <= 1'b0;
          lenb_r <= 1'b0;
          a_r <= chain_r[0]; b_r <= chain_r[1];
          c_r <= chain_r[2]; d_r <= chain_r[3];
          step_r <= '0;
          if (!q_item.no_data) begin
            cnt_r <= cnt_r + 61'd1;
            if (pos == 6'd63) state_r <= ST_COMP;
            else if (q_item.last_byte) state_r <= ST_PAD;
          end else if (q_item.last_byte) begin
            state_r <= ST_PAD;
          end
        end
        ST_COMP: begin
          a_r <= d_r; d_r <= c_r; c_r <= b_r; b_r <= b_r + rot;
          step_r <= step_r + 6'd1;
          if (step_r == 6'd63) begin
            chain_r[0] <= chain_r[0] + d_r;
            chain_r[1] <= chain_r[1] + b_r + rot;
            chain_r[2] <= chain_r[2] + b_r;
            chain_r[3] <= chain_r[3] + c_r;
            if (lenb_r) begin
              state_r <= ST_OUT0; ov_r <= 1'b1; hi_r <= 1'b0;
            end else if (fin_r) state_r <= ST_PAD;
            else state_r <= ST_TAKE;
          end
        end
        ST_PAD: begin
          a_r <= chain_r[0]; b_r <= chain_r[1];
          c_r <= chain_r[2]; d_r <= chain_r[3];
          step_r <= '0;
          state_r <= ST_COMP;
          if (two_r || pos < md5_pkg::LEN_POS) lenb_r <= 1'b1;
          else two_r <= 1'b1;
        end
        ST_OUT0: if (!out_stall) begin
          hi_r <= 1'b1; state_r <= ST_OUT1;
        end
        default: if (!out_stall) begin
          ov_r <= 1'b0; hi_r <= 1'b0; state_r <= ST_TAKE;
          chain_r[0] <= md5_pkg::IV_A; chain_r[1] <= md5_pkg::IV_B;
          chain_r[2] <= md5_pkg::IV_C; chain_r[3] <= md5_pkg::IV_D;
          cnt_r <= '0; fin_r <= 1'b0;
        end
      endcase
    end
  end
endmodule

[src/md5_message_digest_core.sv]
// Top level of the MD5 core: input queue and compression back end.
`timescale 1ns / 1ps
// MD5 message digest core.
// Input channel (in_valid / in_stall / in_item): one message byte per item;
// last_byte ends a message, no_data marks an item without a byte (with
// last_byte it finishes an empty message; alone it does nothing).
// Output channel (out_valid / out_stall / out_item): two items per message,
// digest bytes 0..7 then 8..15, the second flagged by digest_last.
// Timing: the back end stores a byte item as it takes it; a byte that ends
// a 64-byte block starts the 64 MD5 steps, one MD5 step per cycle on a
// single round unit. A message end costs one or two padding passes (a pad
// step and the 64 steps each), then two output items. A small input queue
// keeps taking items while the back end compresses, until it fills.
// Reset: chaining words return to the initial vector and the byte count to
// zero. A stalled result holds its value; the back end waits on it and the
// queue then fills and stalls the sender.
module md5_message_digest_core #(
  parameter int QueueDepth = 4
) (
  input  logic               clk,
  input  logic               rst_n,
  input  logic               in_valid,
  output logic               in_stall,
  input  md5_pkg::in_item_t  in_item,
  output logic               out_valid,
  input  logic               out_stall,
  output md5_pkg::out_item_t out_item
);
  logic q_full, q_empty, q_pop;
  md5_pkg::in_item_t q_item;

  assign in_stall = q_full;

  md5_fifo #(.Depth(QueueDepth)) u_fifo (
    .clk, .rst_n,
    .push(in_valid), .push_item(in_item), .full(q_full),
    .pop(q_pop), .empty(q_empty), .pop_item(q_item)
  );

  md5_engine u_engine (
    .clk, .rst_n,
    .q_empty, .q_item, .q_pop,
    .out_valid, .out_stall, .out_item
  );
endmodule
